FILE: design/ptd_pkg.sv
// Shared types, codes and sizes for the priority task dispatcher.
// Used by every module of the block; depends on nothing.
package ptd_pkg;

    localparam int PRIORITY_LEVELS_DEF = 8;
    localparam int TASK_SLOTS_DEF      = 16;
    localparam int TICK_BITS           = 32;

    typedef enum logic [1:0] {
        OP_READY    = 2'd0,
        OP_DELAY    = 2'd1,
        OP_DISPATCH = 2'd2,
        OP_SLICE    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_ACCEPTED   = 3'd0,
        ST_DISPATCHED = 3'd1,
        ST_IDLE_ADV   = 3'd2,
        ST_IDLE_NONE  = 3'd3,
        ST_LIMIT      = 3'd4,
        ST_FULL       = 3'd5
    } status_t;

    typedef struct packed {
        logic [1:0]           opcode;
        logic [3:0]           task_id;
        logic [2:0]           priority_req;
        logic [TICK_BITS-1:0] delay_ticks;
    } in_item_t;

    typedef struct packed {
        logic [2:0]           status;
        logic [3:0]           chosen_task;
        logic [TICK_BITS-1:0] now_tick;
    } out_item_t;

    typedef struct packed {
        logic                 valid;
        logic [TICK_BITS-1:0] wake;
        logic [3:0]           task_id;
        logic [2:0]           prio;
    } sleep_ent_t;

    typedef struct packed {
        logic                 ins;
        logic                 shl;
        logic [TICK_BITS-1:0] wake;
        logic [3:0]           task_id;
        logic [2:0]           prio;
    } cell_cmd_t;

    typedef struct packed {
        logic       en;
        logic [3:0] task_id;
        logic [2:0] prio;
    } rdy_push_t;

endpackage

FILE: design/ptd_cell.sv
// One cell of the sorted delay list, holding a single sleeper entry.
// Depends on ptd_pkg.
module ptd_cell import ptd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  cell_cmd_t  cmd,
    input  logic       prev_le,
    input  sleep_ent_t left_ent,
    input  sleep_ent_t right_ent,
    output logic       own_le,
    output sleep_ent_t ent
);

    sleep_ent_t ent_reg;
    sleep_ent_t ent_next;

    assign own_le = ent_reg.valid && (ent_reg.wake <= cmd.wake);
    assign ent    = ent_reg;

    always_comb begin
        ent_next = ent_reg;
        if (cmd.shl) begin
            ent_next = right_ent;
        end else if (cmd.ins && !own_le) begin
            if (prev_le) begin
                ent_next.valid   = 1'b1;
                ent_next.wake    = cmd.wake;
                ent_next.task_id = cmd.task_id;
                ent_next.prio    = cmd.prio;
            end else begin
                ent_next = left_ent;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_reg.valid <= 1'b0;
        end else begin
            ent_reg <= ent_next;
        end
    end

endmodule

FILE: design/ptd_ready.sv
// Ready queues: one linked FIFO per priority level, threaded by task id.
// Depends on ptd_pkg.
module ptd_ready import ptd_pkg::*; #(
    parameter int PRIORITY_LEVELS = PRIORITY_LEVELS_DEF,
    parameter int TASK_SLOTS      = TASK_SLOTS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  rdy_push_t  push,
    input  logic       pop_en,
    output logic       push_full,
    output logic       pop_found,
    output logic [3:0] pop_task
);

    localparam int TW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int PW = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
    localparam int CW = $clog2(TASK_SLOTS + 1);

    logic [TW-1:0]              link_reg [TASK_SLOTS];
    logic [TW-1:0]              head_reg [PRIORITY_LEVELS];
    logic [TW-1:0]              tail_reg [PRIORITY_LEVELS];
    logic [PRIORITY_LEVELS-1:0] nonempty_reg;
    logic [TASK_SLOTS-1:0]      queued_reg;
    logic [CW-1:0]              count_reg;

    logic [TW-1:0] pt;
    logic [PW-1:0] pp;
    logic [PW-1:0] hp;
    logic [TW-1:0] ht;
    logic          push_do;

    assign pt        = TW'(push.task_id);
    assign pp        = PW'(push.prio);
    assign push_full = !queued_reg[pt] && (32'(count_reg) >= TASK_SLOTS);
    assign push_do   = push.en && !queued_reg[pt] && !push_full;

    always_comb begin
        hp = '0;
        for (int i = 0; i < PRIORITY_LEVELS; i++) begin
            if (nonempty_reg[i]) begin
                hp = PW'(i);
            end
        end
    end

    assign pop_found = |nonempty_reg;
    assign ht        = head_reg[hp];
    assign pop_task  = 4'(ht);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nonempty_reg <= '0;
            queued_reg   <= '0;
            count_reg    <= '0;
        end else if (push_do) begin
            nonempty_reg[pp] <= 1'b1;
            queued_reg[pt]   <= 1'b1;
            count_reg        <= count_reg + CW'(1);
        end else if (pop_en && pop_found) begin
            if (ht == tail_reg[hp]) begin
                nonempty_reg[hp] <= 1'b0;
            end
            queued_reg[ht] <= 1'b0;
            count_reg      <= count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push_do) begin
            if (nonempty_reg[pp]) begin
                link_reg[tail_reg[pp]] <= pt;
            end else begin
                head_reg[pp] <= pt;
            end
            tail_reg[pp] <= pt;
        end else if (pop_en && pop_found && (ht != tail_reg[hp])) begin
            head_reg[hp] <= link_reg[ht];
        end
    end

endmodule

FILE: design/priority_task_dispatcher_core.sv
// Top level of the priority task dispatcher: sequencer, tick, limit register.
// Depends on ptd_pkg, ptd_cell and ptd_ready.
//
// Usage: operations arrive as beats on the s_ channel (valid/ready); each
// produces exactly one result beat on the m_ channel (valid/ready).
// cfg_we with cfg_wdata writes tick_limit; write it only while
// the block is idle.
// Make ready, delay and end of slice pass through S_EXEC and S_DONE from
// accept to m_valid. Dispatch passes through S_EXEC, stays in S_PROMOTE
// while due sleepers are moved into a ready queue, then S_POP and S_DONE.
// A new beat is taken only in S_IDLE, after the last one has left S_DONE.
// The sequencer handles one operation at a time; the delay list is a chain
// of cells that inserts in sorted order or shifts out its head.
// A new operation is taken while a result beat still waits on m_; the next
// result is held until the receiver takes the pending one.
// Reset clears the tick, empties all queues and the delay list, sets
// tick_limit to all ones and drops any pending result. No clearing pass.
module priority_task_dispatcher_core import ptd_pkg::*; #(
    parameter int PRIORITY_LEVELS = PRIORITY_LEVELS_DEF,
    parameter int TASK_SLOTS      = TASK_SLOTS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [TICK_BITS-1:0] cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data
);

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_EXEC    = 5'b00010,
        S_PROMOTE = 5'b00100,
        S_POP     = 5'b01000,
        S_DONE    = 5'b10000
    } state_t;

    state_t               state_reg;
    in_item_t             item_reg;
    logic [TICK_BITS-1:0] tick_reg;
    logic [TICK_BITS-1:0] limit_reg;
    status_t              res_status_reg;
    logic [3:0]           res_task_reg;
    logic                 m_valid_reg;
    out_item_t            m_data_reg;

    sleep_ent_t           ents [TASK_SLOTS];
    logic [TASK_SLOTS-1:0] le;
    logic [TASK_SLOTS-1:0] vld_vec;
    cell_cmd_t            cmd;
    rdy_push_t            push;
    logic                 push_full;
    logic                 pop_found;
    logic [3:0]           pop_task;

    logic                 id_bad;
    logic [2:0]           prio_c;
    logic [TICK_BITS:0]   wake_sum;
    logic [TICK_BITS-1:0] wake;
    logic                 list_full;
    logic                 due;

    assign id_bad    = 32'(item_reg.task_id) >= TASK_SLOTS;
    assign prio_c    = (32'(item_reg.priority_req) >= PRIORITY_LEVELS) ?
                       3'(PRIORITY_LEVELS - 1) : item_reg.priority_req;
    assign wake_sum  = {1'b0, tick_reg} + {1'b0, item_reg.delay_ticks};
    assign wake      = wake_sum[TICK_BITS] ? '1 : wake_sum[TICK_BITS-1:0];
    assign list_full = ents[TASK_SLOTS-1].valid;
    assign due       = ents[0].valid && (ents[0].wake <= tick_reg);

    always_comb begin
        cmd.ins     = (state_reg == S_EXEC) && (item_reg.opcode == OP_DELAY)
                      && !id_bad && !list_full;
        cmd.shl     = (state_reg == S_PROMOTE) && due;
        cmd.wake    = wake;
        cmd.task_id = item_reg.task_id;
        cmd.prio    = prio_c;
        if (state_reg == S_PROMOTE) begin
            push.en      = due;
            push.task_id = ents[0].task_id;
            push.prio    = ents[0].prio;
        end else begin
            push.en      = (state_reg == S_EXEC) && (item_reg.opcode == OP_READY)
                           && !id_bad;
            push.task_id = item_reg.task_id;
            push.prio    = prio_c;
        end
    end

    for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_cell
        logic       prev_le;
        sleep_ent_t left_ent;
        sleep_ent_t right_ent;
        if (i == 0) begin : g_first
            assign prev_le  = 1'b1;
            assign left_ent = '0;
        end else begin : g_mid
            assign prev_le  = le[i-1];
            assign left_ent = ents[i-1];
        end
        if (i == TASK_SLOTS - 1) begin : g_last
            assign right_ent = '0;
        end else begin : g_inner
            assign right_ent = ents[i+1];
        end
        assign vld_vec[i] = ents[i].valid;
        ptd_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cmd       (cmd),
            .prev_le   (prev_le),
            .left_ent  (left_ent),
            .right_ent (right_ent),
            .own_le    (le[i]),
            .ent       (ents[i])
        );
    end

    ptd_ready #(
        .PRIORITY_LEVELS (PRIORITY_LEVELS),
        .TASK_SLOTS      (TASK_SLOTS)
    ) u_ready (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .pop_en    (state_reg == S_POP),
        .push_full (push_full),
        .pop_found (pop_found),
        .pop_task  (pop_task)
    );

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            tick_reg    <= '0;
            limit_reg   <= '1;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                limit_reg <= cfg_wdata;
            end
            if (state_reg == S_DONE && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (item_reg.opcode == OP_DISPATCH) begin
                        state_reg <= S_PROMOTE;
                    end else begin
                        state_reg <= S_DONE;
                        if (item_reg.opcode == OP_SLICE && tick_reg != '1) begin
                            tick_reg <= tick_reg + TICK_BITS'(1);
                        end
                    end
                end
                S_PROMOTE: begin
                    if (!due) begin
                        state_reg <= S_POP;
                    end
                end
                S_POP: begin
                    state_reg <= S_DONE;
                    if (!pop_found && ents[0].valid) begin
                        if (ents[0].wake >= limit_reg) begin
                            tick_reg <= limit_reg;
                        end else if (ents[0].wake > tick_reg) begin
                            tick_reg <= ents[0].wake;
                        end
                    end
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && s_valid) begin
            item_reg <= s_data;
        end
        if (state_reg == S_EXEC) begin
            res_task_reg <= 4'd0;
            if (item_reg.opcode == OP_DISPATCH || item_reg.opcode == OP_SLICE) begin
                res_status_reg <= ST_ACCEPTED;
            end else if (id_bad) begin
                res_status_reg <= ST_FULL;
            end else if (item_reg.opcode == OP_READY && push_full) begin
                res_status_reg <= ST_FULL;
            end else if (item_reg.opcode == OP_DELAY && list_full) begin
                res_status_reg <= ST_FULL;
            end else begin
                res_status_reg <= ST_ACCEPTED;
            end
        end
        if (state_reg == S_POP) begin
            if (pop_found) begin
                res_status_reg <= ST_DISPATCHED;
                res_task_reg   <= pop_task;
            end else if (!ents[0].valid) begin
                res_status_reg <= ST_IDLE_NONE;
            end else if (ents[0].wake >= limit_reg) begin
                res_status_reg <= ST_LIMIT;
            end else begin
                res_status_reg <= ST_IDLE_ADV;
            end
        end
        if (state_reg == S_DONE && (!m_valid_reg || m_ready)) begin
            m_data_reg.status      <= res_status_reg;
            m_data_reg.chosen_task <= res_task_reg;
            m_data_reg.now_tick    <= tick_reg;
        end
    end

    a_list_packed: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot({1'b0, vld_vec} + {{TASK_SLOTS{1'b0}}, 1'b1}))
        else $error("Delay list has a gap between valid cells.");

    for (genvar j = 0; j + 1 < TASK_SLOTS; j++) begin : g_sorted_chk
        a_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
            ents[j+1].valid |-> (ents[j].wake <= ents[j+1].wake))
            else $error("Delay list is out of wake order.");
    end

    a_no_due_left: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_POP) |-> !due)
        else $error("Due sleeper left in the list at pop time.");

    a_result_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && (!m_valid_reg || m_ready)) |=> m_valid_reg)
        else $error("Result beat was not presented.");

endmodule
